[hdl/boxds_pkg.sv]
package boxds_pkg;

    localparam int MAX_OUT_WIDTH    = 256;
    localparam int MAX_FACTOR       = 16;
    localparam int OUT_HEIGHT_LIMIT = 256;

    localparam int COL_W     = $clog2(MAX_OUT_WIDTH);
    localparam int SUB_W     = $clog2(MAX_FACTOR);
    localparam int ROW_W     = $clog2(OUT_HEIGHT_LIMIT);
    localparam int CHAN_W    = 8;
    localparam int PIXEL_W   = 32;
    localparam int SUM_W     = CHAN_W + 2 * SUB_W;
    localparam int ACC_W     = 3 * SUM_W;
    localparam int FACTOR_W  = 5;
    localparam int DIM_W     = 9;
    localparam int CFG_W     = 9;
    localparam int REG_IDX_W = 2;

    // floor(x / n) == (x * ceil(2^24 / n)) >> 24 for every x below 2^16
    localparam int RECIP_SHIFT = 24;
    localparam int RECIP_W     = 25;
    localparam int PROD_W      = SUM_W + RECIP_W;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_SCALE_FACTOR = 2'd0,
        REG_OUT_WIDTH    = 2'd1,
        REG_OUT_HEIGHT   = 2'd2
    } t_reg_idx;

    // indexed by factor - 1, entry holds ceil(2^24 / factor^2)
    localparam logic [RECIP_W-1:0] RECIP_TABLE [MAX_FACTOR] = '{
        25'd16777216, 25'd4194304, 25'd1864136, 25'd1048576,
        25'd671089,   25'd466034,  25'd342393,  25'd262144,
        25'd207127,   25'd167773,  25'd138655,  25'd116509,
        25'd99274,    25'd85599,   25'd74566,   25'd65536
    };

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic              first;
        logic              emit;
        logic              last;
        logic [COL_W-1:0]  col;
    } t_cmd;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic              last;
    } t_result;

    typedef struct packed {
        logic             we;
        logic [COL_W-1:0] waddr;
        logic [ACC_W-1:0] wdata;
        logic             re;
        logic [COL_W-1:0] raddr;
    } t_ram_req;

    typedef enum logic [1:0] {
        BK_IDLE = 2'd0,
        BK_ACC  = 2'd1,
        BK_MUL  = 2'd2,
        BK_OUT  = 2'd3
    } t_back_state;

endpackage

[hdl/boxds_ram.sv]
module boxds_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/boxds_front.sv]
module boxds_front import boxds_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  logic [PIXEL_W-1:0]   i_pixel_argb,
    input  logic                 i_cmd_full,
    output logic                 o_cmd_push,
    output t_cmd                 o_cmd,
    input  logic                 i_cfg_we,
    input  logic [REG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output logic [SUB_W-1:0]     o_factor_m1
);

    logic [FACTOR_W-1:0] r_scale_factor, n_scale_factor;
    logic [DIM_W-1:0]    r_out_width, n_out_width;
    logic [DIM_W-1:0]    r_out_height, n_out_height;
    logic [COL_W-1:0]    r_out_col, n_out_col;
    logic [SUB_W-1:0]    r_sub_col, n_sub_col;
    logic [SUB_W-1:0]    r_sub_row, n_sub_row;
    logic [ROW_W-1:0]    r_out_row, n_out_row;

    logic [SUB_W-1:0] factor_m1;
    logic [COL_W-1:0] width_m1;
    logic [ROW_W-1:0] height_m1;
    logic             accept;
    logic             cfg_hit;

    // clamp registers into their working ranges
    always_comb begin
        if (r_scale_factor == '0) begin
            factor_m1 = '0;
        end else if (r_scale_factor > FACTOR_W'(MAX_FACTOR)) begin
            factor_m1 = SUB_W'(MAX_FACTOR - 1);
        end else begin
            factor_m1 = SUB_W'(r_scale_factor - FACTOR_W'(1));
        end

        if (r_out_width == '0) begin
            width_m1 = '0;
        end else if (r_out_width > DIM_W'(MAX_OUT_WIDTH)) begin
            width_m1 = COL_W'(MAX_OUT_WIDTH - 1);
        end else begin
            width_m1 = COL_W'(r_out_width - DIM_W'(1));
        end

        if (r_out_height == '0) begin
            height_m1 = '0;
        end else if (r_out_height > DIM_W'(OUT_HEIGHT_LIMIT)) begin
            height_m1 = ROW_W'(OUT_HEIGHT_LIMIT - 1);
        end else begin
            height_m1 = ROW_W'(r_out_height - DIM_W'(1));
        end
    end

    assign accept      = i_push && !i_cmd_full;
    assign o_cmd_push  = accept;
    assign o_factor_m1 = factor_m1;

    always_comb begin
        o_cmd.red   = i_pixel_argb[23:16];
        o_cmd.green = i_pixel_argb[15:8];
        o_cmd.blue  = i_pixel_argb[7:0];
        o_cmd.first = (r_sub_row == '0) && (r_sub_col == '0);
        o_cmd.emit  = (r_sub_row == factor_m1) && (r_sub_col == factor_m1);
        o_cmd.last  = (r_out_row == height_m1) && (r_out_col == width_m1);
        o_cmd.col   = r_out_col;
    end

    always_comb begin
        n_scale_factor = r_scale_factor;
        n_out_width    = r_out_width;
        n_out_height   = r_out_height;
        n_out_col      = r_out_col;
        n_sub_col      = r_sub_col;
        n_sub_row      = r_sub_row;
        n_out_row      = r_out_row;
        cfg_hit        = 1'b0;

        if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_SCALE_FACTOR: begin
                    n_scale_factor = i_cfg_data[FACTOR_W-1:0];
                    cfg_hit        = 1'b1;
                end
                REG_OUT_WIDTH: begin
                    n_out_width = i_cfg_data[DIM_W-1:0];
                    cfg_hit     = 1'b1;
                end
                REG_OUT_HEIGHT: begin
                    n_out_height = i_cfg_data[DIM_W-1:0];
                    cfg_hit      = 1'b1;
                end
                default: begin
                    cfg_hit = 1'b0;
                end
            endcase
        end

        if (cfg_hit) begin
            // restart the tile
            n_out_col = '0;
            n_sub_col = '0;
            n_sub_row = '0;
            n_out_row = '0;
        end else if (accept) begin
            if (r_sub_col == factor_m1) begin
                n_sub_col = '0;
                if (r_out_col == width_m1) begin
                    n_out_col = '0;
                    if (r_sub_row == factor_m1) begin
                        n_sub_row = '0;
                        n_out_row = (r_out_row == height_m1) ? '0 : r_out_row + ROW_W'(1);
                    end else begin
                        n_sub_row = r_sub_row + SUB_W'(1);
                    end
                end else begin
                    n_out_col = r_out_col + COL_W'(1);
                end
            end else begin
                n_sub_col = r_sub_col + SUB_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale_factor <= FACTOR_W'(1);
            r_out_width    <= DIM_W'(MAX_OUT_WIDTH);
            r_out_height   <= DIM_W'(OUT_HEIGHT_LIMIT);
            r_out_col      <= '0;
            r_sub_col      <= '0;
            r_sub_row      <= '0;
            r_out_row      <= '0;
        end else begin
            r_scale_factor <= n_scale_factor;
            r_out_width    <= n_out_width;
            r_out_height   <= n_out_height;
            r_out_col      <= n_out_col;
            r_sub_col      <= n_sub_col;
            r_sub_row      <= n_sub_row;
            r_out_row      <= n_out_row;
        end
    end

endmodule

[hdl/boxds_cmd_q.sv]
module boxds_cmd_q import boxds_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_cmd
);

    t_cmd       r_mem [2];
    logic       r_wr_ptr, n_wr_ptr;
    logic       r_rd_ptr, n_rd_ptr;
    logic [1:0] r_count, n_count;
    logic       do_push;
    logic       do_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = do_push ? !r_wr_ptr : r_wr_ptr;
        n_rd_ptr = do_pop ? !r_rd_ptr : r_rd_ptr;
        n_count  = r_count + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

[hdl/boxds_back.sv]
module boxds_back import boxds_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cmd_valid,
    input  t_cmd             i_cmd,
    output logic             o_cmd_pop,
    input  logic [SUB_W-1:0] i_factor_m1,
    output t_ram_req         o_ram_req,
    input  logic [ACC_W-1:0] i_ram_rdata,
    output logic             o_empty,
    input  logic             i_pop,
    output t_result          o_result
);

    t_back_state r_state, n_state;
    t_cmd        r_cmd, n_cmd;

    logic [SUM_W-1:0]  r_sum_r, n_sum_r;
    logic [SUM_W-1:0]  r_sum_g, n_sum_g;
    logic [SUM_W-1:0]  r_sum_b, n_sum_b;
    logic [PROD_W-1:0] r_prod_r, n_prod_r;
    logic [PROD_W-1:0] r_prod_g, n_prod_g;
    logic [PROD_W-1:0] r_prod_b, n_prod_b;

    logic [SUM_W-1:0]   acc_r, acc_g, acc_b;
    logic [RECIP_W-1:0] recip;

    t_result    r_out_mem [2];
    logic       r_out_wr, n_out_wr;
    logic       r_out_rd, n_out_rd;
    logic [1:0] r_out_count, n_out_count;
    logic       out_full;
    logic       out_push;
    logic       out_pop;
    t_result    out_word;

    assign recip = RECIP_TABLE[i_factor_m1];

    // first pixel of a box overwrites the column, the rest add to it
    always_comb begin
        if (r_cmd.first) begin
            acc_r = SUM_W'(r_cmd.red);
            acc_g = SUM_W'(r_cmd.green);
            acc_b = SUM_W'(r_cmd.blue);
        end else begin
            acc_r = i_ram_rdata[3*SUM_W-1:2*SUM_W] + SUM_W'(r_cmd.red);
            acc_g = i_ram_rdata[2*SUM_W-1:SUM_W] + SUM_W'(r_cmd.green);
            acc_b = i_ram_rdata[SUM_W-1:0] + SUM_W'(r_cmd.blue);
        end
    end

    always_comb begin
        out_word.red   = r_prod_r[RECIP_SHIFT +: CHAN_W];
        out_word.green = r_prod_g[RECIP_SHIFT +: CHAN_W];
        out_word.blue  = r_prod_b[RECIP_SHIFT +: CHAN_W];
        out_word.last  = r_cmd.last;
    end

    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_sum_r   = r_sum_r;
        n_sum_g   = r_sum_g;
        n_sum_b   = r_sum_b;
        n_prod_r  = r_prod_r;
        n_prod_g  = r_prod_g;
        n_prod_b  = r_prod_b;
        o_cmd_pop = 1'b0;
        o_ram_req = '0;
        out_push  = 1'b0;

        case (r_state)
            BK_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop       = 1'b1;
                    o_ram_req.re    = 1'b1;
                    o_ram_req.raddr = i_cmd.col;
                    n_cmd           = i_cmd;
                    n_state         = BK_ACC;
                end
            end
            BK_ACC: begin
                o_ram_req.we    = 1'b1;
                o_ram_req.waddr = r_cmd.col;
                o_ram_req.wdata = {acc_r, acc_g, acc_b};
                n_sum_r         = acc_r;
                n_sum_g         = acc_g;
                n_sum_b         = acc_b;
                n_state         = r_cmd.emit ? BK_MUL : BK_IDLE;
            end
            BK_MUL: begin
                n_prod_r = PROD_W'(r_sum_r) * PROD_W'(recip);
                n_prod_g = PROD_W'(r_sum_g) * PROD_W'(recip);
                n_prod_b = PROD_W'(r_sum_b) * PROD_W'(recip);
                n_state  = BK_OUT;
            end
            BK_OUT: begin
                // hold until the result queue has room
                if (!out_full) begin
                    out_push = 1'b1;
                    n_state  = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    assign out_full = (r_out_count == 2'd2);
    assign o_empty  = (r_out_count == 2'd0);
    assign out_pop  = i_pop && !o_empty;
    assign o_result = r_out_mem[r_out_rd];

    always_comb begin
        n_out_wr    = out_push ? !r_out_wr : r_out_wr;
        n_out_rd    = out_pop ? !r_out_rd : r_out_rd;
        n_out_count = r_out_count + 2'(out_push) - 2'(out_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_out_wr    <= 1'b0;
            r_out_rd    <= 1'b0;
            r_out_count <= 2'd0;
        end else begin
            r_state     <= n_state;
            r_out_wr    <= n_out_wr;
            r_out_rd    <= n_out_rd;
            r_out_count <= n_out_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_sum_r  <= n_sum_r;
        r_sum_g  <= n_sum_g;
        r_sum_b  <= n_sum_b;
        r_prod_r <= n_prod_r;
        r_prod_g <= n_prod_g;
        r_prod_b <= n_prod_b;
        if (out_push) begin
            r_out_mem[r_out_wr] <= out_word;
        end
    end

`ifndef SYNTHESIS
    a_acc_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == BK_ACC |-> $past(r_state) == BK_IDLE)
        else $error("accumulate step without a preceding column read");

    a_mul_only_on_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_MUL || r_state == BK_OUT) |-> r_cmd.emit)
        else $error("divide path entered for a word that closes no box");

    a_out_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_count != 2'd3)
        else $error("result queue count out of range");

    a_push_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_push |=> r_out_count != 2'd0)
        else $error("pushed result missing from the result queue");
`endif

endmodule

[hdl/box_downsample_argb_to_rgb.sv]
// Box-filter downsampler. Source ARGB pixels of a tile arrive in raster order,
// out_width*scale_factor per row, out_height*scale_factor rows; every
// scale_factor x scale_factor block yields one RGB pixel, each channel the
// truncated average of the block (alpha ignored), in raster order, with
// last_pixel set on the tile's final output. A write to any of the three
// configuration registers restarts the tile at the next pixel. A pixel pushed
// while full is low enters a two-word command queue in that cycle, and the back
// end drains that queue one pixel at a time: a pixel that only updates its
// column accumulator in the 256 x 48 RAM takes a read step, then an
// add-and-write step; a pixel that closes a block also takes a reciprocal
// multiply step and a result stage, which holds while the two-word result queue
// in front of the output is full. The back end takes no new pixel until it is
// through with the last one. The accumulator RAM needs no clearing after reset.
module box_downsample_argb_to_rgb import boxds_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic [PIXEL_W-1:0]   i_pixel_argb,
    output logic                 empty,
    input  logic                 pop,
    output logic [CHAN_W-1:0]    o_red,
    output logic [CHAN_W-1:0]    o_green,
    output logic [CHAN_W-1:0]    o_blue,
    output logic                 o_last_pixel,
    input  logic                 i_cfg_we,
    input  logic [REG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    logic             cmd_push;
    t_cmd             cmd_in;
    logic             cmd_full;
    logic             cmd_pop;
    logic             cmd_valid;
    t_cmd             cmd_out;
    logic [SUB_W-1:0] factor_m1;
    t_ram_req         ram_req;
    logic [ACC_W-1:0] ram_rdata;
    t_result          result;

    boxds_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_pixel_argb (i_pixel_argb),
        .i_cmd_full   (cmd_full),
        .o_cmd_push   (cmd_push),
        .o_cmd        (cmd_in),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_factor_m1  (factor_m1)
    );

    boxds_cmd_q u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_cmd   (cmd_in),
        .o_full  (cmd_full),
        .i_pop   (cmd_pop),
        .o_valid (cmd_valid),
        .o_cmd   (cmd_out)
    );

    boxds_ram #(
        .WIDTH (ACC_W),
        .DEPTH (MAX_OUT_WIDTH)
    ) u_acc_ram (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (ram_req.wdata),
        .i_re    (ram_req.re),
        .i_raddr (ram_req.raddr),
        .o_rdata (ram_rdata)
    );

    boxds_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd_out),
        .o_cmd_pop   (cmd_pop),
        .i_factor_m1 (factor_m1),
        .o_ram_req   (ram_req),
        .i_ram_rdata (ram_rdata),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_result    (result)
    );

    assign full         = cmd_full;
    assign o_red        = result.red;
    assign o_green      = result.green;
    assign o_blue       = result.blue;
    assign o_last_pixel = result.last;

endmodule
